/* rtl/core/phti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phti_pkg: shared types for the pose history interpolator
// Transaction payload structs and command codes.
// ----------------------------------------------------------------------------
package phti_pkg;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               command;
        logic        [63:0] time_stamp;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               valid_res;
    } out_item_t;

    typedef struct packed {
        logic        [63:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } sample_t;

endpackage

/* rtl/core/phti_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phti_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module phti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/phti_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phti_div: 16-bit fraction divider
// Restoring division, one quotient bit per cycle: floor(num * 65536 / den).
// ----------------------------------------------------------------------------
module phti_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [15:0] quot
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [15:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic        take;

    assign shifted = {rem_reg, 1'b0};
    assign take    = shifted[64] || (shifted[63:0] >= den_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = take ? (shifted[63:0] - den_reg) : shifted[63:0];
            q_next   = {q_reg[14:0], take};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* rtl/core/phti_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phti_blend: axis-serial linear blend
// One axis per cycle: (cur*(65536-r) + prev*r + 32768) >> 16, registered.
// ----------------------------------------------------------------------------
module phti_blend (
    input  logic               clk,
    input  logic signed [31:0] cur,
    input  logic signed [31:0] prev,
    input  logic        [15:0] ratio,
    output logic signed [31:0] res
);

    logic signed [49:0] pa_reg;
    logic signed [49:0] pb_reg;
    logic signed [17:0] wcur;
    logic signed [17:0] wprev;
    logic signed [50:0] sum;

    assign wcur  = 18'sd65536 - $signed({2'b00, ratio});
    assign wprev = $signed({2'b00, ratio});
    assign sum   = 51'(pa_reg) + 51'(pb_reg) + 51'sd32768;

    always_ff @(posedge clk)
    begin
        pa_reg <= cur * wcur;
        pb_reg <= prev * wprev;
        res    <= sum[47:16];
    end

endmodule

/* rtl/core/pose_history_time_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_history_time_interpolator: timestamped position history
// Pushes append to a circular history; queries interpolate or clamp by time.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall/in_data): command 0 pushes a sample,
//   command 1 queries the position at time_stamp.
//   out channel (out_valid/out_stall/out_data): one transaction per query.
//   A query spends a read state and a compare state on each history
//   entry it visits (one RAM read port, registered read), scanning up to
//   all N stored samples. A clamped result goes straight to the output;
//   an interpolated one first passes a bit-serial divide and an
//   axis-serial blend.
//   One transaction is in flight at a time; in_stall is high while busy.
//   The result sits in an output register; while a stalled receiver holds
//   it, in_stall stays high and no input is accepted.
//   Reset empties the history at once; RAM contents need no clearing.
//   A query on an empty history returns zeros with valid_res low.
// ----------------------------------------------------------------------------
module pose_history_time_interpolator
    import phti_pkg::*;
#(
    parameter int HISTORY_DEPTH = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = $bits(sample_t);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_READ  = 8'b0000_0010,
        ST_CHECK = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_BLEND = 8'b0001_0000,
        ST_OUT   = 8'b0010_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   oldest_reg, oldest_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [63:0]     q_reg, q_next;
    sample_t         prev_reg, prev_next;
    sample_t         hit_reg, hit_next;
    logic [1:0]      axis_reg, axis_next;
    logic [2:0]      bl_reg, bl_next;
    logic            interp_reg, interp_next;
    out_item_t       res_reg, res_next;
    logic            ov_reg, ov_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    sample_t         wr_data;
    sample_t         rd_data;
    logic [AW:0]     sum_addr;
    logic            div_start;
    logic            div_done;
    logic [15:0]     ratio;
    logic signed [31:0] bl_cur, bl_prev, bl_res;
    logic            accept;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] a);
        logic [AW:0] r;
        r = (a >= (AW+1)'(HISTORY_DEPTH)) ? a - (AW+1)'(HISTORY_DEPTH) : a;
        return r[AW-1:0];
    endfunction

    phti_ram #(.WIDTH(SW), .DEPTH(HISTORY_DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    phti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (hit_reg.t - q_reg),
        .den   (hit_reg.t - prev_reg.t),
        .done  (div_done),
        .quot  (ratio)
    );

    phti_blend u_blend (
        .clk   (clk),
        .cur   (bl_cur),
        .prev  (bl_prev),
        .ratio (ratio),
        .res   (bl_res)
    );

    assign in_stall = (state_reg != ST_IDLE) || (ov_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        case (axis_reg)
            2'd0:    begin bl_cur = hit_reg.x; bl_prev = prev_reg.x; end
            2'd1:    begin bl_cur = hit_reg.y; bl_prev = prev_reg.y; end
            default: begin bl_cur = hit_reg.z; bl_prev = prev_reg.z; end
        endcase
    end

    assign sum_addr = {1'b0, oldest_reg} + (AW+1)'(pos_reg);
    assign rd_addr  = wrap(sum_addr);

    always_comb
    begin
        state_next  = state_reg;
        oldest_next = oldest_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        q_next      = q_reg;
        prev_next   = prev_reg;
        hit_next    = hit_reg;
        axis_next   = axis_reg;
        bl_next     = bl_reg;
        interp_next = interp_reg;
        res_next    = res_reg;
        ov_next     = ov_reg && out_stall;
        wr_en       = 1'b0;
        wr_addr     = wrap({1'b0, oldest_reg} + (AW+1)'(count_reg));
        wr_data     = '{t: in_data.time_stamp, x: in_data.pos_x,
                        y: in_data.pos_y, z: in_data.pos_z};
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.command == CMD_PUSH)
                    begin
                        wr_en = 1'b1;
                        if (count_reg < CW'(HISTORY_DEPTH))
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            wr_addr     = oldest_reg;
                            oldest_next = wrap({1'b0, oldest_reg} + (AW+1)'(1));
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next = '0;
                        ov_next  = 1'b1;
                    end
                    else
                    begin
                        q_next     = in_data.time_stamp;
                        pos_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if ((pos_reg + CW'(1) < count_reg) && (q_reg > rd_data.t))
                begin
                    prev_next  = rd_data;
                    pos_next   = pos_reg + CW'(1);
                    state_next = ST_READ;
                end
                else
                begin
                    hit_next = rd_data;
                    if ((pos_reg == '0) || (q_reg > rd_data.t))
                    begin
                        interp_next = 1'b0;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        interp_next = 1'b1;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (!interp_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (!bl_reg[0])
                begin
                    div_start = 1'b1;
                    bl_next   = 3'd1;
                end
                else if (div_done)
                begin
                    axis_next  = 2'd0;
                    bl_next    = 3'd0;
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                bl_next = bl_reg + 3'd1;
                if (bl_reg == 3'd0)
                begin
                    axis_next = 2'd1;
                end
                if (bl_reg == 3'd1)
                begin
                    axis_next = 2'd2;
                end
                if (bl_reg == 3'd2)
                begin
                    res_next.out_x = bl_res;
                end
                if (bl_reg == 3'd3)
                begin
                    res_next.out_y = bl_res;
                end
                if (bl_reg == 3'd4)
                begin
                    res_next.out_z = bl_res;
                    bl_next        = 3'd0;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!(ov_reg && out_stall))
                begin
                    if (!interp_reg)
                    begin
                        res_next.out_x = hit_reg.x;
                        res_next.out_y = hit_reg.y;
                        res_next.out_z = hit_reg.z;
                    end
                    res_next.valid_res = 1'b1;
                    ov_next            = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            oldest_reg <= '0;
            count_reg  <= '0;
            ov_reg     <= 1'b0;
            bl_reg     <= '0;
            axis_reg   <= '0;
            interp_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            ov_reg     <= ov_next;
            bl_reg     <= bl_next;
            axis_reg   <= axis_next;
            interp_reg <= interp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        q_reg    <= q_next;
        prev_reg <= prev_next;
        hit_reg  <= hit_next;
        res_reg  <= res_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = res_reg;

endmodule

/* tb/pose_history_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_history_checker: result predictor and comparator
// Watches the input and output channels of the pose history interpolator,
// keeps its own copy of the sample history, predicts each query result and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module pose_history_checker
    import phti_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    output int        mismatches,
    output int        pending,
    output int        queries_seen,
    output int        blends_seen
);

    sample_t   history[DEPTH];
    int        oldest;
    int        count;
    out_item_t expected_positions[$];

    function automatic logic [15:0] time_ratio(logic [63:0] num, logic [63:0] den);
        logic [127:0] wide;
        wide = {64'd0, num} << 16;
        return 16'(wide / {64'd0, den});
    endfunction

    function automatic logic signed [31:0] mix(logic signed [31:0] cur,
                                              logic signed [31:0] prev,
                                              logic [15:0] r);
        logic signed [63:0] acc;
        acc = 64'(cur) * (64'sd65536 - 64'(r)) + 64'(prev) * 64'(r) + 64'sd32768;
        return 32'(acc >>> 16);
    endfunction

    task automatic predict_position(input in_item_t item);
        out_item_t res;
        int        pos;
        sample_t   hit;
        sample_t   prv;
        logic [15:0] r;
        res = '0;
        if (count > 0)
        begin
            pos = 0;
            hit = history[oldest % DEPTH];
            while (pos + 1 < count && item.time_stamp > hit.t)
            begin
                pos++;
                hit = history[(oldest + pos) % DEPTH];
            end
            if (pos == 0 || item.time_stamp > hit.t)
            begin
                res.out_x = hit.x;
                res.out_y = hit.y;
                res.out_z = hit.z;
            end
            else
            begin
                prv = history[(oldest + pos - 1) % DEPTH];
                r = time_ratio(hit.t - item.time_stamp, hit.t - prv.t);
                res.out_x = mix(hit.x, prv.x, r);
                res.out_y = mix(hit.y, prv.y, r);
                res.out_z = mix(hit.z, prv.z, r);
                blends_seen++;
            end
            res.valid_res = 1'b1;
        end
        expected_positions = {expected_positions, res};
        queries_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest = 0;
            count = 0;
            mismatches = 0;
            queries_seen = 0;
            blends_seen = 0;
            expected_positions.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_positions.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", out_data);
                end
                else if (out_data !== expected_positions[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%h y=%h z=%h v=%b, got x=%h y=%h z=%h v=%b",
                            expected_positions[0].out_x, expected_positions[0].out_y,
                            expected_positions[0].out_z, expected_positions[0].valid_res,
                            out_data.out_x, out_data.out_y, out_data.out_z,
                            out_data.valid_res);
                    void'(expected_positions.pop_front());
                end
                else
                    void'(expected_positions.pop_front());
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.command == CMD_PUSH)
                begin
                    if (count < DEPTH)
                    begin
                        history[(oldest + count) % DEPTH] = {in_data.time_stamp,
                            in_data.pos_x, in_data.pos_y, in_data.pos_z};
                        count++;
                    end
                    else
                    begin
                        history[oldest] = {in_data.time_stamp,
                            in_data.pos_x, in_data.pos_y, in_data.pos_z};
                        oldest = (oldest + 1) % DEPTH;
                    end
                end
                else
                    predict_position(in_data);
            end
        end
    end

    assign pending = expected_positions.size();

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pose history interpolator
// Drives directed and random pushes and queries with random idle and stall,
// including history wraparound, unsorted times and extreme positions.
// ----------------------------------------------------------------------------
module testbench;
    import phti_pkg::*;

    localparam int WATCHDOG = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    int        mismatches;
    int        pending;
    int        queries_seen;
    int        blends_seen;
    int        idle_cycles;
    int        calm;
    logic [63:0] clock_ns;

    pose_history_time_interpolator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    pose_history_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .mismatches(mismatches), .pending(pending),
        .queries_seen(queries_seen), .blends_seen(blends_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (in_valid && !in_stall || out_valid && !out_stall)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= (calm == 0) && ($urandom_range(99) < 27);

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic cmd, input logic [63:0] ts,
                        input logic [31:0] x, input logic [31:0] y,
                        input logic [31:0] z);
        while (calm == 0 && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= {cmd, ts, x, y, z};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic push_track(input int n);
        repeat (n)
        begin
            clock_ns = clock_ns + $urandom_range(1, 100000);
            send(CMD_PUSH, clock_ns, rand_pos(), rand_pos(), rand_pos());
        end
    endtask

    task automatic query_near();
        logic [63:0] q;
        case ($urandom_range(3))
            0: q = clock_ns - $urandom_range(0, 3000000);
            1: q = {$urandom, $urandom};
            default: q = clock_ns - $urandom_range(0, 200000);
        endcase
        send(CMD_QUERY, q, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        idle_cycles = 0;
        calm = 0;
        clock_ns = 64'd1000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(CMD_QUERY, 64'd0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send(CMD_PUSH, 64'd1000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        send(CMD_QUERY, 64'd0, '0, '0, '0);
        send(CMD_QUERY, 64'hffff_ffff_ffff_ffff, '0, '0, '0);
        send(CMD_PUSH, 64'd3000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000);
        send(CMD_QUERY, 64'd1000, '0, '0, '0);
        send(CMD_QUERY, 64'd1001, '0, '0, '0);
        send(CMD_QUERY, 64'd2000, '0, '0, '0);
        send(CMD_QUERY, 64'd2999, '0, '0, '0);
        send(CMD_QUERY, 64'd3000, '0, '0, '0);
        send(CMD_PUSH, 64'hffff_ffff_ffff_ffff, 32'h0, 32'h7fff_ffff, 32'h8000_0000);
        send(CMD_QUERY, 64'hffff_ffff_ffff_fffe, '0, '0, '0);
        send(CMD_PUSH, 64'd500, 32'h1234_5678, 32'h0, 32'hffff_ffff);
        send(CMD_QUERY, 64'd600, '0, '0, '0);
        send(CMD_QUERY, 64'h8000_0000_0000_0000, '0, '0, '0);

        for (int i = 0; i < 300; i++)
        begin
            calm = (i >= 100 && i < 160) ? 1 : 0;
            if ($urandom_range(99) < 55)
                push_track(1);
            else if ($urandom_range(9) == 0)
                send(CMD_PUSH, {$urandom, $urandom}, rand_pos(), rand_pos(), rand_pos());
            else
                query_near();
        end
        calm = 0;
        push_track(270);
        for (int i = 0; i < 360; i++)
        begin
            if ($urandom_range(99) < 30)
                push_track(1);
            else
                query_near();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("covered %0d queries, %0d interpolated, with history wraparound",
            queries_seen, blends_seen);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
